### rtl/tbflc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbflc_pkg
// Shared types, codes and character constants of the text byte filter and
// line counter.
// ----------------------------------------------------------------------------
package tbflc_pkg;

    // Mode register codes
    localparam logic [1:0] MODE_DROP_DIGITS  = 2'd0;
    localparam logic [1:0] MODE_COUNT_ROMAN  = 2'd1;
    localparam logic [1:0] MODE_COUNT_SPEC   = 2'd2;
    localparam logic [1:0] MODE_HEX_ESCAPE   = 2'd3;

    // Characters
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_ROMAN_I   = 8'h49;
    localparam logic [7:0] CH_ROMAN_V   = 8'h56;
    localparam logic [7:0] CH_ROMAN_X   = 8'h58;
    localparam logic [7:0] CH_ROMAN_L   = 8'h4C;
    localparam logic [7:0] CH_ROMAN_C   = 8'h43;
    localparam logic [7:0] CH_ROMAN_D   = 8'h44;
    localparam logic [7:0] CH_ROMAN_M   = 8'h4D;

    // Work kinds passed from front to back
    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_HEX,
        KIND_REPORT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEX,
        ST_CONV,
        ST_DIGIT,
        ST_NEWLINE
    } t_state;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'b0000, nib};
        end else begin
            ch = CH_UPPER_A + {4'b0000, nib - 4'd10};
        end
        return ch;
    endfunction

endpackage

### rtl/tbflc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbflc_front
// Accepts input bytes, classifies them by mode, keeps the running count and
// queues one command per byte that produces output.
// ----------------------------------------------------------------------------
module tbflc_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_mode,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_full,
    output logic                   o_push,
    output tbflc_pkg::t_cmd        o_cmd,
    output logic [COUNT_WIDTH-1:0] o_count
);
    import tbflc_pkg::*;

    logic [1:0]             r_mode;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] bumped;
    logic                   accept;
    logic                   is_digit;
    logic                   is_roman;
    logic                   is_alnum_space;
    logic                   is_newline;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_full;
    assign accept      = i_in_valid && !i_full;

    assign is_digit   = (i_in_byte >= CH_ZERO) && (i_in_byte <= CH_NINE);
    assign is_newline = (i_in_byte == CH_NEWLINE);
    assign is_roman   = (i_in_byte == CH_ROMAN_I) || (i_in_byte == CH_ROMAN_V) ||
                        (i_in_byte == CH_ROMAN_X) || (i_in_byte == CH_ROMAN_L) ||
                        (i_in_byte == CH_ROMAN_C) || (i_in_byte == CH_ROMAN_D) ||
                        (i_in_byte == CH_ROMAN_M);
    assign is_alnum_space = ((i_in_byte >= CH_LOWER_A) && (i_in_byte <= CH_LOWER_Z)) ||
                            ((i_in_byte >= CH_UPPER_A) && (i_in_byte <= CH_UPPER_Z)) ||
                            is_digit || (i_in_byte == CH_SPACE);

    // saturating increment
    assign bumped = (r_count == {COUNT_WIDTH{1'b1}}) ? r_count : r_count + 1'b1;

    always_comb begin
        o_push     = 1'b0;
        o_cmd.kind = KIND_BYTE;
        o_cmd.data = i_in_byte;
        o_count    = r_count;
        n_count    = r_count;
        unique case (r_mode)
            MODE_DROP_DIGITS: begin
                o_push = accept && !is_digit;
            end
            MODE_COUNT_ROMAN: begin
                if (is_roman) begin
                    n_count = bumped;
                end else if (is_newline) begin
                    o_push     = accept;
                    o_cmd.kind = KIND_REPORT;
                    n_count    = '0;
                end
            end
            MODE_COUNT_SPEC: begin
                // the newline itself counts before it is reported
                o_count = is_alnum_space ? r_count : bumped;
                n_count = o_count;
                if (is_newline) begin
                    o_push     = accept;
                    o_cmd.kind = KIND_REPORT;
                    n_count    = '0;
                end
            end
            MODE_HEX_ESCAPE: begin
                o_push     = accept;
                o_cmd.kind = is_digit ? KIND_BYTE : KIND_HEX;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DROP_DIGITS;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_mode;
            end
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

endmodule

### rtl/tbflc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbflc_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tbflc_queue #(
    parameter int DATA_WIDTH = 26,
    parameter int DEPTH      = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr;
    logic [PTR_W-1:0]      r_rd;
    logic [CNT_W-1:0]      r_fill;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_fill == CNT_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

### rtl/tbflc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbflc_back
// Carries out queued commands: plain bytes, hex escapes, and count reports
// through a bit-serial binary to BCD conversion.
// ----------------------------------------------------------------------------
module tbflc_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  tbflc_pkg::t_cmd        i_cmd,
    input  logic [COUNT_WIDTH-1:0] i_count,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_last
);
    import tbflc_pkg::*;

    // decimal digits of the largest count
    localparam int NUM_DIGITS = (COUNT_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int BIT_W      = $clog2(COUNT_WIDTH);
    localparam int DIG_W      = $clog2(NUM_DIGITS);

    t_state                 r_state;
    t_state                 n_state;
    logic [COUNT_WIDTH-1:0] r_bin;
    logic [COUNT_WIDTH-1:0] n_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       n_bcd;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BIT_W-1:0]       r_bit;
    logic [BIT_W-1:0]       n_bit;
    logic [DIG_W-1:0]       r_dig;
    logic [DIG_W-1:0]       n_dig;
    logic                   r_started;
    logic                   n_started;
    logic [7:0]             r_data;
    logic [7:0]             n_data;
    logic [1:0]             r_idx;
    logic [1:0]             n_idx;
    logic                   r_valid;
    logic                   n_valid;
    logic [7:0]             r_byte;
    logic [7:0]             n_byte;
    logic                   r_last;
    logic                   n_last;

    logic                   can_load;
    logic                   conv_done;
    logic [3:0]             cur_digit;
    logic                   skip_zero;

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

    assign can_load  = !r_valid || i_out_ready;
    assign conv_done = (r_bit == BIT_W'(COUNT_WIDTH - 1));
    assign cur_digit = r_bcd[{r_dig, 2'b00} +: 4];
    // drop leading zeros, but keep the units digit
    assign skip_zero = (cur_digit == 4'd0) && !r_started && (r_dig != '0);

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            bcd_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ?
                                r_bcd[d*4 +: 4] + 4'd3 : r_bcd[d*4 +: 4];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.kind)
                        KIND_HEX:    if (can_load) n_state = ST_HEX;
                        KIND_REPORT: n_state = ST_CONV;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_HEX: begin
                if (can_load && (r_idx == 2'd3)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (!skip_zero && can_load && (r_dig == '0)) begin
                    n_state = ST_NEWLINE;
                end
            end
            ST_NEWLINE: begin
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_pop     = 1'b0;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_bit     = r_bit;
        n_dig     = r_dig;
        n_started = r_started;
        n_data    = r_data;
        n_idx     = r_idx;
        n_valid   = r_valid && !i_out_ready;
        n_byte    = r_byte;
        n_last    = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.kind)
                        KIND_HEX: begin
                            if (can_load) begin
                                o_pop   = 1'b1;
                                n_data  = i_cmd.data;
                                n_idx   = 2'd1;
                                n_valid = 1'b1;
                                n_byte  = CH_BACKSLASH;
                                n_last  = 1'b0;
                            end
                        end
                        KIND_REPORT: begin
                            o_pop = 1'b1;
                            n_bin = i_count;
                            n_bcd = '0;
                            n_bit = '0;
                        end
                        default: begin
                            if (can_load) begin
                                o_pop   = 1'b1;
                                n_valid = 1'b1;
                                n_byte  = i_cmd.data;
                                n_last  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_HEX: begin
                if (can_load) begin
                    n_valid = 1'b1;
                    n_last  = (r_idx == 2'd3);
                    n_idx   = r_idx + 2'd1;
                    unique case (r_idx)
                        2'd1:    n_byte = CH_LOWER_X;
                        2'd2:    n_byte = hex_char(r_data[7:4]);
                        default: n_byte = hex_char(r_data[3:0]);
                    endcase
                end
            end
            ST_CONV: begin
                // shift one bit into the BCD digits
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[COUNT_WIDTH-1]};
                n_bin = {r_bin[COUNT_WIDTH-2:0], 1'b0};
                n_bit = r_bit + 1'b1;
                if (conv_done) begin
                    n_dig     = DIG_W'(NUM_DIGITS - 1);
                    n_started = 1'b0;
                end
            end
            ST_DIGIT: begin
                if (skip_zero) begin
                    n_dig = r_dig - 1'b1;
                end else if (can_load) begin
                    n_valid   = 1'b1;
                    n_byte    = CH_ZERO + {4'b0000, cur_digit};
                    n_last    = 1'b0;
                    n_started = 1'b1;
                    if (r_dig != '0) begin
                        n_dig = r_dig - 1'b1;
                    end
                end
            end
            ST_NEWLINE: begin
                if (can_load) begin
                    n_valid = 1'b1;
                    n_byte  = CH_NEWLINE;
                    n_last  = 1'b1;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_bit     <= n_bit;
        r_dig     <= n_dig;
        r_started <= n_started;
        r_data    <= n_data;
        r_idx     <= n_idx;
        r_byte    <= n_byte;
        r_last    <= n_last;
    end

endmodule

### rtl/text_byte_filter_line_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_byte_filter_line_counter_unit
// Text byte filter with a per-line counter of Roman letters or special bytes.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------
//   cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_mode (2 b)
//   in      | in        | i_in_valid/o_in_ready   | i_in_byte (8 b)
//   out     | out       | o_out_valid/i_out_ready | o_out_byte (8 b), o_last
//
// A plain byte gives one output byte, a dropped byte none; a hex escape gives
// four output bytes, one at a time through the single output register.
// A count report is dequeued, converted bit-serially from binary to BCD, then
// sent one decimal digit position at a time and closed by a newline.
// The command queue lets input bytes be taken while the back end is busy.
// Reset is synchronous and active low; it clears mode and count to zero.
// ----------------------------------------------------------------------------
module text_byte_filter_line_counter_unit #(
    parameter int COUNT_WIDTH = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_mode,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import tbflc_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int Q_W   = CMD_W + COUNT_WIDTH;

    logic                   push;
    logic                   pop;
    logic                   full;
    logic                   empty;
    t_cmd                   front_cmd;
    logic [COUNT_WIDTH-1:0] front_count;
    logic [Q_W-1:0]         q_wdata;
    logic [Q_W-1:0]         q_rdata;
    t_cmd                   back_cmd;
    logic [COUNT_WIDTH-1:0] back_count;

    assign q_wdata    = {front_cmd, front_count};
    assign back_cmd   = t_cmd'(q_rdata[Q_W-1 -: CMD_W]);
    assign back_count = q_rdata[COUNT_WIDTH-1:0];

    tbflc_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_mode  (i_cfg_mode),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .o_count     (front_count)
    );

    tbflc_queue #(
        .DATA_WIDTH (Q_W),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_empty (empty)
    );

    tbflc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (back_cmd),
        .i_count     (back_count),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

### rtl/tbflc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbflc_checker
// Port-level checks of the text byte filter and line counter.
// ----------------------------------------------------------------------------
module tbflc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last
);
    import tbflc_pkg::*;

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_byte) && $stable(o_last))
        else $error("output item changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // only escape and report sequences span several items
    a_mid_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |->
            (o_out_byte == CH_BACKSLASH) || (o_out_byte == CH_LOWER_X) ||
            ((o_out_byte >= CH_ZERO) && (o_out_byte <= CH_NINE)) ||
            ((o_out_byte >= CH_UPPER_A) && (o_out_byte <= CH_UPPER_F)))
        else $error("unexpected byte inside a multi-byte sequence");

endmodule

bind text_byte_filter_line_counter_unit tbflc_checker u_tbflc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);
